// ===== hw/rtl/pse_pkg.sv =====
// Shared types and constants for the postfix stack evaluator.
package pse_pkg;

    // Default number of operand stack entries
    localparam int STACK_DEPTH_DEF = 16;

    // Data and field widths
    localparam int DATA_W   = 64;
    localparam int CMD_W    = 5;
    localparam int STATUS_W = 3;

    // Token operation codes
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 5'd0,
        CMD_NOT   = 5'd1,
        CMD_COMPL = 5'd2,
        CMD_ADD   = 5'd3,
        CMD_SUB   = 5'd4,
        CMD_MUL   = 5'd5,
        CMD_DIV   = 5'd6,
        CMD_MOD   = 5'd7,
        CMD_SHL   = 5'd8,
        CMD_SHR   = 5'd9,
        CMD_AND   = 5'd10,
        CMD_OR    = 5'd11,
        CMD_XOR   = 5'd12,
        CMD_LT    = 5'd13,
        CMD_GT    = 5'd14,
        CMD_LE    = 5'd15,
        CMD_GE    = 5'd16,
        CMD_EQ    = 5'd17,
        CMD_NE    = 5'd18
    } t_cmd;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIV0  = 3'd3,
        ST_SHIFT = 3'd4
    } t_status;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_DIVEND,
        S_FINISH
    } t_state;

endpackage

// ===== hw/rtl/pse_if.sv =====
// Handshake interfaces for the token and result channels.
interface pse_tok_if;
    logic                         valid;
    logic                         ready;
    logic [pse_pkg::CMD_W-1:0]    cmd;
    logic signed [pse_pkg::DATA_W-1:0] literal_value;
    logic                         last_token;

    modport source (output valid, output cmd, output literal_value, output last_token,
                    input ready);
    modport sink   (input valid, input cmd, input literal_value, input last_token,
                    output ready);
endinterface

interface pse_res_if;
    logic                              valid;
    logic                              ready;
    logic signed [pse_pkg::DATA_W-1:0] result_value;
    logic [pse_pkg::STATUS_W-1:0]      status;

    modport source (output valid, output result_value, output status, input ready);
    modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== hw/rtl/postfix_stack_evaluator.sv =====
// Postfix evaluator: one token request at a time; the operand stack lives in a
// synchronous memory with the top entry held in a register. Push, not, compl and
// tokens ignored after an error are handled in the idle state; binary operators
// read the second entry from memory and then execute, mul then forms three 32x32
// partial products on one multiplier, and div and mod produce one quotient bit
// per cycle. A last token goes on to a finish state that posts the result; the
// result sits in an output register, and the next token is taken while it waits.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    pse_tok_if.sink      i_tok,
    pse_res_if.source    o_res
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int DW = pse_pkg::DATA_W;

    // Control state
    pse_pkg::t_state  r_state, n_state;
    pse_pkg::t_status r_err;
    logic [CW-1:0]    r_count;
    logic             r_ov;

    // Datapath registers
    pse_pkg::t_cmd    r_cmd;
    logic             r_last;
    logic [DW-1:0]    r_tos;
    logic [DW-1:0]    r_rd;
    logic [DW-1:0]    r_opa, r_opb, r_acc;
    logic [1:0]       r_mstep;
    logic [DW-1:0]    r_quo, r_rem, r_dvs;
    logic [5:0]       r_dstep;
    logic             r_qneg, r_rneg;
    logic [DW-1:0]    r_rv;
    pse_pkg::t_status r_rs;

    // Stack memory (entries below the top)
    logic [DW-1:0]    mem [STACK_DEPTH];

    logic             tok_fire, fin_fire, push_we, rd_en, in_ok, is_bin;
    pse_pkg::t_cmd    in_cmd;
    logic [CW-1:0]    cnt_m1, cnt_m2;
    logic [DW-1:0]    a, b, alu, ma, mb, prod, shifted_add;
    logic [31:0]      mx, my;
    logic [DW:0]      dsh, ddiff;

    assign in_cmd   = pse_pkg::t_cmd'(i_tok.cmd);
    assign tok_fire = i_tok.valid && i_tok.ready;
    assign fin_fire = (r_state == pse_pkg::S_FINISH) && (!r_ov || o_res.ready);
    assign in_ok    = (r_err == pse_pkg::ST_OK) && (in_cmd <= pse_pkg::CMD_NE);
    assign is_bin   = (in_cmd >= pse_pkg::CMD_ADD);
    assign cnt_m1   = r_count - CW'(1);
    assign cnt_m2   = r_count - CW'(2);
    assign push_we  = tok_fire && in_ok && (in_cmd == pse_pkg::CMD_PUSH)
                      && (r_count != '0) && (r_count < CW'(STACK_DEPTH));
    assign rd_en    = tok_fire && in_ok && is_bin && (r_count >= CW'(2));

    assign i_tok.ready        = (r_state == pse_pkg::S_IDLE);
    assign o_res.valid        = r_ov;
    assign o_res.result_value = r_rv;
    assign o_res.status       = r_rs;

    // Operands: second entry from memory, top from register
    assign a  = r_rd;
    assign b  = r_tos;
    assign ma = a[DW-1] ? (~a + DW'(1)) : a;
    assign mb = b[DW-1] ? (~b + DW'(1)) : b;

    // Combinational ALU operators
    always_comb begin
        alu = '0;
        case (r_cmd)
            pse_pkg::CMD_ADD: alu = a + b;
            pse_pkg::CMD_SUB: alu = a - b;
            pse_pkg::CMD_SHL: alu = a << b[5:0];
            pse_pkg::CMD_SHR: alu = DW'($signed(a) >>> b[5:0]);
            pse_pkg::CMD_AND: alu = a & b;
            pse_pkg::CMD_OR:  alu = a | b;
            pse_pkg::CMD_XOR: alu = a ^ b;
            pse_pkg::CMD_LT:  alu = DW'($signed(a) <  $signed(b));
            pse_pkg::CMD_GT:  alu = DW'($signed(a) >  $signed(b));
            pse_pkg::CMD_LE:  alu = DW'($signed(a) <= $signed(b));
            pse_pkg::CMD_GE:  alu = DW'($signed(a) >= $signed(b));
            pse_pkg::CMD_EQ:  alu = DW'(a == b);
            pse_pkg::CMD_NE:  alu = DW'(a != b);
            default:          alu = '0;
        endcase
    end

    // Shared 32x32 multiplier, one partial product per step
    always_comb begin
        case (r_mstep)
            2'd0:    begin mx = r_opa[31:0];  my = r_opb[31:0];  end
            2'd1:    begin mx = r_opa[31:0];  my = r_opb[63:32]; end
            default: begin mx = r_opa[63:32]; my = r_opb[31:0];  end
        endcase
        prod        = mx * my;
        shifted_add = r_acc + {prod[31:0], 32'd0};
    end

    // Restoring divider step
    assign dsh   = {r_rem, r_quo[DW-1]};
    assign ddiff = dsh - {1'b0, r_dvs};

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pse_pkg::S_IDLE: begin
                if (rd_en)
                    n_state = pse_pkg::S_EXEC;
                else if (tok_fire && i_tok.last_token)
                    n_state = pse_pkg::S_FINISH;
            end
            pse_pkg::S_EXEC: begin
                if (r_cmd == pse_pkg::CMD_MUL)
                    n_state = pse_pkg::S_MUL;
                else if ((r_cmd == pse_pkg::CMD_DIV || r_cmd == pse_pkg::CMD_MOD) && b != '0)
                    n_state = pse_pkg::S_DIV;
                else
                    n_state = r_last ? pse_pkg::S_FINISH : pse_pkg::S_IDLE;
            end
            pse_pkg::S_MUL: begin
                if (r_mstep == 2'd2)
                    n_state = r_last ? pse_pkg::S_FINISH : pse_pkg::S_IDLE;
            end
            pse_pkg::S_DIV: begin
                if (r_dstep == 6'd63)
                    n_state = pse_pkg::S_DIVEND;
            end
            pse_pkg::S_DIVEND: n_state = r_last ? pse_pkg::S_FINISH : pse_pkg::S_IDLE;
            pse_pkg::S_FINISH: begin
                if (fin_fire)
                    n_state = pse_pkg::S_IDLE;
            end
            default: n_state = pse_pkg::S_IDLE;
        endcase
    end

    // Sequencer and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pse_pkg::S_IDLE;
            r_count <= '0;
            r_err   <= pse_pkg::ST_OK;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            // a new result posted in the same cycle keeps the flag set
            if (o_res.valid && o_res.ready && !fin_fire)
                r_ov <= 1'b0;
            unique case (r_state)
                pse_pkg::S_IDLE: begin
                    if (tok_fire) begin
                        r_cmd  <= in_cmd;
                        r_last <= i_tok.last_token;
                        if (in_ok) begin
                            if (in_cmd == pse_pkg::CMD_PUSH) begin
                                if (r_count >= CW'(STACK_DEPTH)) begin
                                    r_err <= pse_pkg::ST_OVER;
                                end else begin
                                    r_tos   <= i_tok.literal_value;
                                    r_count <= r_count + CW'(1);
                                end
                            end else if (!is_bin) begin
                                if (r_count == '0)
                                    r_err <= pse_pkg::ST_UNDER;
                                else if (in_cmd == pse_pkg::CMD_NOT)
                                    r_tos <= DW'(r_tos == '0);
                                else
                                    r_tos <= ~r_tos;
                            end else if (r_count < CW'(2)) begin
                                r_err <= pse_pkg::ST_UNDER;
                            end
                        end
                    end
                end
                pse_pkg::S_EXEC: begin
                    case (r_cmd)
                        pse_pkg::CMD_MUL: begin
                            r_opa   <= a;
                            r_opb   <= b;
                            r_mstep <= 2'd0;
                            r_acc   <= '0;
                        end
                        pse_pkg::CMD_DIV, pse_pkg::CMD_MOD: begin
                            if (b == '0) begin
                                r_err <= pse_pkg::ST_DIV0;
                            end else begin
                                r_quo   <= ma;
                                r_rem   <= '0;
                                r_dvs   <= mb;
                                r_dstep <= '0;
                                r_qneg  <= a[DW-1] ^ b[DW-1];
                                r_rneg  <= a[DW-1];
                            end
                        end
                        pse_pkg::CMD_SHL, pse_pkg::CMD_SHR: begin
                            if (b > DW'(63)) begin
                                r_err <= pse_pkg::ST_SHIFT;
                            end else begin
                                r_tos   <= alu;
                                r_count <= cnt_m1;
                            end
                        end
                        default: begin
                            r_tos   <= alu;
                            r_count <= cnt_m1;
                        end
                    endcase
                end
                pse_pkg::S_MUL: begin
                    r_mstep <= r_mstep + 2'd1;
                    if (r_mstep == 2'd0)
                        r_acc <= prod;
                    else
                        r_acc <= shifted_add;
                    if (r_mstep == 2'd2) begin
                        r_tos   <= shifted_add;
                        r_count <= cnt_m1;
                    end
                end
                pse_pkg::S_DIV: begin
                    r_dstep <= r_dstep + 6'd1;
                    if (!ddiff[DW]) begin
                        r_rem <= ddiff[DW-1:0];
                        r_quo <= {r_quo[DW-2:0], 1'b1};
                    end else begin
                        r_rem <= dsh[DW-1:0];
                        r_quo <= {r_quo[DW-2:0], 1'b0};
                    end
                end
                pse_pkg::S_DIVEND: begin
                    if (r_cmd == pse_pkg::CMD_DIV)
                        r_tos <= r_qneg ? (~r_quo + DW'(1)) : r_quo;
                    else
                        r_tos <= r_rneg ? (~r_rem + DW'(1)) : r_rem;
                    r_count <= cnt_m1;
                end
                pse_pkg::S_FINISH: begin
                    if (fin_fire) begin
                        r_ov <= 1'b1;
                        if (r_err != pse_pkg::ST_OK) begin
                            r_rv <= '0;
                            r_rs <= r_err;
                        end else if (r_count == '0) begin
                            r_rv <= '0;
                            r_rs <= pse_pkg::ST_UNDER;
                        end else begin
                            r_rv <= r_tos;
                            r_rs <= pse_pkg::ST_OK;
                        end
                        r_count <= '0;
                        r_err   <= pse_pkg::ST_OK;
                    end
                end
                default: ;
            endcase
        end
    end

    // Stack memory: old top spills on push, second entry read for binary ops
    always_ff @(posedge i_clk) begin
        if (push_we)
            mem[cnt_m1[AW-1:0]] <= r_tos;
        if (rd_en)
            r_rd <= mem[cnt_m2[AW-1:0]];
    end

`ifndef SYNTHESIS
    // Stack count never exceeds the depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count above depth");

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_rs != pse_pkg::ST_OK) |-> (r_rv == '0))
        else $error("error result with nonzero value");

    // A recorded error freezes the stack until the result is posted
    a_err_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != pse_pkg::ST_OK && r_state != pse_pkg::S_FINISH)
        |=> (r_count == $past(r_count)))
        else $error("stack moved after error");

    // Posting a result clears the stack
    a_finish_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_fire |=> (r_count == '0 && r_err == pse_pkg::ST_OK && r_ov))
        else $error("stack not cleared after result");
`endif

endmodule

// ===== tb/sv/postfix_stack_evaluator_tb.sv =====
// Self-checking testbench for the postfix stack evaluator token and result channels.
module postfix_stack_evaluator_tb;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic signed [pse_pkg::DATA_W-1:0] value;
        logic [pse_pkg::STATUS_W-1:0]      status;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pse_tok_if tok ();
    pse_res_if res ();

    postfix_stack_evaluator #(.STACK_DEPTH(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok.sink),
        .o_res   (res.source)
    );

    always #4 i_clk = ~i_clk;

    // Predictor state
    logic [pse_pkg::DATA_W-1:0]   eval_stack [DEPTH];
    int                           eval_count;
    logic [pse_pkg::STATUS_W-1:0] eval_err;
    t_answer                      answers_due [$];
    int                           fail_count;
    int                           tokens_sent;
    int                           results_seen;
    bit                           res_stall_on;

    function automatic logic [pse_pkg::DATA_W-1:0] op_result(pse_pkg::t_cmd c,
                                                             logic [pse_pkg::DATA_W-1:0] a,
                                                             logic [pse_pkg::DATA_W-1:0] b);
        logic signed [pse_pkg::DATA_W-1:0] sa, sb;
        logic [pse_pkg::DATA_W-1:0] ma, mb, q, m;
        sa = a;
        sb = b;
        ma = a[pse_pkg::DATA_W-1] ? -a : a;
        mb = b[pse_pkg::DATA_W-1] ? -b : b;
        q = ma / mb;
        m = ma % mb;
        case (c)
            pse_pkg::CMD_ADD: return a + b;
            pse_pkg::CMD_SUB: return a - b;
            pse_pkg::CMD_MUL: return a * b;
            pse_pkg::CMD_DIV: return (a[pse_pkg::DATA_W-1] ^ b[pse_pkg::DATA_W-1]) ? -q : q;
            pse_pkg::CMD_MOD: return a[pse_pkg::DATA_W-1] ? -m : m;
            pse_pkg::CMD_SHL: return a << b[5:0];
            pse_pkg::CMD_SHR: return sa >>> b[5:0];
            pse_pkg::CMD_AND: return a & b;
            pse_pkg::CMD_OR:  return a | b;
            pse_pkg::CMD_XOR: return a ^ b;
            pse_pkg::CMD_LT:  return {63'd0, sa < sb};
            pse_pkg::CMD_GT:  return {63'd0, sa > sb};
            pse_pkg::CMD_LE:  return {63'd0, sa <= sb};
            pse_pkg::CMD_GE:  return {63'd0, sa >= sb};
            pse_pkg::CMD_EQ:  return {63'd0, a == b};
            default:          return {63'd0, a != b};
        endcase
    endfunction

    // Advance the predicted stack by one token; queue a result on last
    task automatic evaluate_token(logic [pse_pkg::CMD_W-1:0] c,
                                  logic [pse_pkg::DATA_W-1:0] lit, logic lst);
        t_answer ans;
        logic [pse_pkg::DATA_W-1:0] a, b;
        if (eval_err == pse_pkg::ST_OK && c <= pse_pkg::CMD_NE) begin
            if (c == pse_pkg::CMD_PUSH) begin
                if (eval_count >= DEPTH) eval_err = pse_pkg::ST_OVER;
                else begin
                    eval_stack[eval_count] = lit;
                    eval_count++;
                end
            end else if (c <= pse_pkg::CMD_COMPL) begin
                if (eval_count < 1) eval_err = pse_pkg::ST_UNDER;
                else begin
                    a = eval_stack[eval_count-1];
                    eval_stack[eval_count-1] = (c == pse_pkg::CMD_NOT) ? {63'd0, a == 0} : ~a;
                end
            end else if (eval_count < 2) begin
                eval_err = pse_pkg::ST_UNDER;
            end else begin
                a = eval_stack[eval_count-2];
                b = eval_stack[eval_count-1];
                if ((c == pse_pkg::CMD_DIV || c == pse_pkg::CMD_MOD) && b == 0)
                    eval_err = pse_pkg::ST_DIV0;
                else if ((c == pse_pkg::CMD_SHL || c == pse_pkg::CMD_SHR) && b > 63)
                    eval_err = pse_pkg::ST_SHIFT;
                else begin
                    eval_stack[eval_count-2] = op_result(pse_pkg::t_cmd'(c), a, b);
                    eval_count--;
                end
            end
        end
        if (lst) begin
            if (eval_err == pse_pkg::ST_OK && eval_count == 0) eval_err = pse_pkg::ST_UNDER;
            ans.value = (eval_err == pse_pkg::ST_OK) ? eval_stack[eval_count-1] : '0;
            ans.status = eval_err;
            answers_due = {answers_due, ans};
            eval_count = 0;
            eval_err = pse_pkg::ST_OK;
        end
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Send one token request and wait for acceptance
    task automatic send_token(logic [pse_pkg::CMD_W-1:0] c,
                              logic [pse_pkg::DATA_W-1:0] lit, logic lst);
        int g;
        g = gap_len();
        if (g > 0) begin
            tok.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        tok.valid <= 1'b1;
        tok.cmd <= c;
        tok.literal_value <= lit;
        tok.last_token <= lst;
        evaluate_token(c, lit, lst);
        tokens_sent++;
        @(posedge i_clk);
        while (!tok.ready) @(posedge i_clk);
    endtask

    task automatic drop_valid();
        tok.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [pse_pkg::DATA_W-1:0] rand_lit();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7fff_ffff_ffff_ffff;
            2: return -64'sd1;
            3: return 64'($urandom_range(0, 70));
            4: return -64'($urandom_range(1, 70));
            5: return {32'd0, $urandom};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Directed: every operator, extremes and each error case
    task automatic test_directed();
        logic [pse_pkg::DATA_W-1:0] minv, maxv;
        minv = 64'h8000_0000_0000_0000;
        maxv = 64'h7fff_ffff_ffff_ffff;
        send_token(pse_pkg::CMD_PUSH, minv, 1'b0);
        send_token(pse_pkg::CMD_PUSH, -64'sd1, 1'b0);
        send_token(pse_pkg::CMD_DIV, '0, 1'b1);          // min / -1 wraps
        send_token(pse_pkg::CMD_PUSH, minv, 1'b0);
        send_token(pse_pkg::CMD_PUSH, -64'sd1, 1'b0);
        send_token(pse_pkg::CMD_MOD, '0, 1'b1);
        send_token(pse_pkg::CMD_PUSH, 64'd5, 1'b0);
        send_token(pse_pkg::CMD_PUSH, '0, 1'b0);
        send_token(pse_pkg::CMD_DIV, '0, 1'b0);          // divide by zero, then ignored
        send_token(pse_pkg::CMD_ADD, '0, 1'b1);
        send_token(pse_pkg::CMD_PUSH, maxv, 1'b0);
        send_token(pse_pkg::CMD_PUSH, 64'd64, 1'b0);
        send_token(pse_pkg::CMD_SHL, '0, 1'b1);          // bad shift count
        send_token(pse_pkg::CMD_NOT, '0, 1'b1);          // underflow
        send_token(5'd31, maxv, 1'b1);                   // unknown cmd on empty stack
        for (int k = 0; k <= DEPTH; k++) send_token(pse_pkg::CMD_PUSH, 64'(k), 1'b0);
        send_token(pse_pkg::CMD_PUSH, '0, 1'b1);         // result reports the overflow
        send_token(pse_pkg::CMD_PUSH, '0, 1'b0);
        send_token(pse_pkg::CMD_NOT, '0, 1'b0);
        send_token(pse_pkg::CMD_COMPL, '0, 1'b1);
        for (int c = pse_pkg::CMD_ADD; c <= pse_pkg::CMD_NE; c++) begin
            send_token(pse_pkg::CMD_PUSH, minv, 1'b0);
            send_token(pse_pkg::CMD_PUSH, 64'd63, 1'b0);
            send_token(5'(c), '0, 1'b1);
        end
    endtask

    // Random: mostly well-formed expressions, some noise
    task automatic test_random(int n_tok);
        int depth, len;
        logic [pse_pkg::CMD_W-1:0] c;
        while (n_tok > 0) begin
            depth = 0;
            len = $urandom_range(1, 14);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 19) == 0) c = 5'($urandom_range(0, 31));
                else if (depth < 2 || ($urandom_range(0, 2) == 0 && depth < DEPTH))
                    c = pse_pkg::CMD_PUSH;
                else if ($urandom_range(0, 5) == 0) c = 5'($urandom_range(1, 2));
                else c = 5'($urandom_range(3, 18));
                if (c == pse_pkg::CMD_PUSH) depth++;
                else if (c >= pse_pkg::CMD_ADD && c <= pse_pkg::CMD_NE) depth--;
                send_token(c, rand_lit(), k == len - 1);
                n_tok--;
            end
        end
    endtask

    // Result checker with random stalls
    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            res.ready <= 1'b0;
        end else begin
            if (res.valid && res.ready) begin
                results_seen++;
                if (answers_due.size() == 0) begin
                    $error("result with none pending: value %0d status %0d",
                           res.result_value, res.status);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    if (res.result_value !== want.value) begin
                        $error("result_value: expected %0d got %0d", want.value,
                               res.result_value);
                        fail_count++;
                    end
                    if (res.status !== want.status) begin
                        $error("status: expected %0d got %0d", want.status, res.status);
                        fail_count++;
                    end
                end
            end
            res.ready <= res_stall_on ? ($urandom_range(0, 99) < 60) : 1'b1;
            if ($urandom_range(0, 199) == 0) res_stall_on <= ~res_stall_on;
        end
    end

    initial begin
        tok.valid = 1'b0;
        tok.cmd = '0;
        tok.literal_value = '0;
        tok.last_token = 1'b0;
        res.ready = 1'b0;
        fail_count = 0;
        tokens_sent = 0;
        results_seen = 0;
        res_stall_on = 1'b1;
        eval_count = 0;
        eval_err = pse_pkg::ST_OK;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1880);
        drop_valid();
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d tokens, checked %0d results, all operators and error paths.",
                 tokens_sent, results_seen);
        if (fail_count == 0 && answers_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
